FILE: rtl/airw_pkg.sv
// ----------------------------------------------------------------------------
// airw_pkg
// Shared types and constants of the acknowledgement anti-replay window table.
// ----------------------------------------------------------------------------
package airw_pkg;

  localparam int ENTRIES = 8;
  localparam int WINDOW = 32;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = 4;
  localparam logic [31:0] HALF_RANGE = 32'h8000_0000;
  localparam logic [26:0] AGE_CAP = 27'd86400000;
  localparam logic [31:0] WIN_MASK = 32'hFFFF_FFFF >> (32 - WINDOW);

  typedef enum logic [1:0] {
    KIND_BIND = 2'd0,
    KIND_UNBIND = 2'd1,
    KIND_ACK = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_OK = 4'd0,
    ST_INVALID = 4'd1,
    ST_DUP_CONSUMER = 4'd2,
    ST_FULL = 4'd3,
    ST_UNKNOWN = 4'd4,
    ST_CLOCK = 4'd5,
    ST_CONSUMER = 4'd6,
    ST_PRODUCER = 4'd7,
    ST_SESSION = 4'd8,
    ST_AGE = 4'd9,
    ST_DUPLICATE = 4'd10,
    ST_AMBIGUOUS = 4'd11,
    ST_TOO_OLD = 4'd12
  } status_t;

  localparam logic REG_PRODUCER = 1'b0;
  localparam logic REG_MAX_AGE = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] peer;
    logic [63:0] consumer;
    logic [31:0] session;
  } key_t;

  typedef struct packed {
    logic seq_seen;
    logic [31:0] top;
    logic [31:0] bits;
  } win_t;

  typedef struct packed {
    logic we;
    logic [IDX_W-1:0] addr;
    win_t data;
  } win_wr_t;

endpackage

FILE: rtl/ack_ingress_replay_window_table_core.sv
// ----------------------------------------------------------------------------
// ack_ingress_replay_window_table_core
// Peer binding table with a per-peer sliding anti-replay window.
// ----------------------------------------------------------------------------
// A beat that is accepted is registered into the request registers. In the READ
// state the peer is looked up in the key registers and the window-store read
// is issued; in the DONE state the registered read data is checked and the
// output register is loaded. The input stalls outside the idle state and while
// a result is held, so the next beat is taken at the earliest in the idle state
// after the result is loaded, together with the taking of that result: a new
// beat is never taken before the previous one has been through DONE.
module ack_ingress_replay_window_table_core (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic cfg_index,
  input logic [63:0] cfg_data,
  input logic in_valid,
  output logic in_stall,
  input logic [1:0] kind,
  input logic [31:0] peer_id,
  input logic [63:0] consumer_ident,
  input logic [31:0] session_id,
  input logic [63:0] producer_ident,
  input logic [31:0] observed_age_ms,
  input logic [31:0] seq_num,
  input logic [63:0] now_ms,
  output logic out_valid,
  input logic out_stall,
  output logic [3:0] status,
  output logic [3:0] bound_total,
  output logic [31:0] top_seq
);
  import airw_pkg::*;

  logic [63:0] own_producer;
  logic [26:0] max_age;
  logic [ENTRIES-1:0] valid;
  key_t keys [ENTRIES];
  logic [CNT_W-1:0] count;
  logic clock_seen;
  logic [63:0] last_time;

  state_t state, state_next;
  kind_t r_kind;
  logic [31:0] r_peer, r_session, r_age, r_seq;
  logic [63:0] r_consumer, r_producer, r_now;

  logic [ENTRIES-1:0] hit_v, dup_v;
  logic [IDX_W-1:0] hit_idx, free_idx;
  logic hit, dup, free_ok;
  logic [IDX_W-1:0] m_idx;
  logic m_hit;
  win_t rd_data, upd;
  win_wr_t wr;
  status_t w_status, st;
  logic [26:0] lim;
  logic take;
  logic out_load;

  assign take = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  always_comb begin
    hit_idx = '0;
    free_idx = '0;
    free_ok = 1'b0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      hit_v[i] = valid[i] && keys[i].peer == r_peer;
      dup_v[i] = valid[i] && keys[i].peer != r_peer && keys[i].consumer == r_consumer;
      if (hit_v[i]) hit_idx = IDX_W'(i);
      if (!valid[i]) begin
        free_idx = IDX_W'(i);
        free_ok = 1'b1;
      end
    end
    hit = |hit_v;
    dup = |dup_v;
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      m_idx <= hit_idx;
      m_hit <= hit;
    end
  end

  airw_win_ram u_ram (
    .clk(clk),
    .rd_addr(hit_idx),
    .rd_data(rd_data),
    .wr(wr)
  );

  airw_window u_win (
    .cur(rd_data),
    .seq(r_seq),
    .status(w_status),
    .upd(upd)
  );

  assign lim = (max_age > AGE_CAP) ? AGE_CAP : max_age;

  always_comb begin
    st = ST_INVALID;
    unique case (r_kind)
      KIND_BIND: begin
        if (r_peer == '0 || r_consumer == '0 || r_session == '0) st = ST_INVALID;
        else if (dup) st = ST_DUP_CONSUMER;
        else if (!m_hit && !free_ok) st = ST_FULL;
        else st = ST_OK;
      end
      KIND_UNBIND: st = m_hit ? ST_OK : ST_UNKNOWN;
      KIND_ACK: begin
        if (clock_seen && r_now < last_time) st = ST_CLOCK;
        else if (!m_hit) st = ST_UNKNOWN;
        else if (r_consumer != keys[m_idx].consumer) st = ST_CONSUMER;
        else if (r_producer != own_producer) st = ST_PRODUCER;
        else if (r_session != keys[m_idx].session) st = ST_SESSION;
        else if (r_age > {5'd0, lim}) st = ST_AGE;
        else st = w_status;
      end
      default: st = ST_INVALID;
    endcase
  end

  always_comb begin
    wr.we = 1'b0;
    wr.addr = m_hit ? m_idx : free_idx;
    wr.data = upd;
    if (state == S_DONE && st == ST_OK) begin
      if (r_kind == KIND_BIND) begin
        wr.we = 1'b1;
        wr.data = '0;
      end else if (r_kind == KIND_ACK) begin
        wr.we = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (take) state_next = S_READ;
      S_READ: state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign out_load = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (take) begin
      r_kind <= kind_t'(kind);
      r_peer <= peer_id;
      r_consumer <= consumer_ident;
      r_session <= session_id;
      r_producer <= producer_ident;
      r_age <= observed_age_ms;
      r_seq <= seq_num;
      r_now <= now_ms;
    end
    if (state == S_DONE && st == ST_OK && r_kind == KIND_BIND) begin
      keys[wr.addr] <= '{peer: r_peer, consumer: r_consumer, session: r_session};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      own_producer <= 64'd1;
      max_age <= AGE_CAP;
      valid <= '0;
      count <= '0;
      clock_seen <= 1'b0;
      last_time <= '0;
      out_valid <= 1'b0;
      status <= '0;
      bound_total <= '0;
      top_seq <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == REG_PRODUCER) own_producer <= cfg_data;
        else max_age <= cfg_data[26:0];
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (out_load) begin
        out_valid <= 1'b1;
        status <= st;
        top_seq <= '0;
        bound_total <= count;
        if (st == ST_OK) begin
          unique case (r_kind)
            KIND_BIND: begin
              if (!m_hit) begin
                valid[free_idx] <= 1'b1;
                bound_total <= count + 1'b1;
                count <= count + 1'b1;
              end
            end
            KIND_UNBIND: begin
              valid[m_idx] <= 1'b0;
              bound_total <= count - 1'b1;
              count <= count - 1'b1;
            end
            KIND_ACK: begin
              clock_seen <= 1'b1;
              last_time <= r_now;
              top_seq <= upd.top;
            end
            default: ;
          endcase
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count == CNT_W'($countones(valid)))
    else $error("binding count differs from valid entries");
  assert property (@(posedge clk) disable iff (rst) $onehot0(hit_v))
    else $error("peer bound in more than one entry");
  assert property (@(posedge clk) disable iff (rst) out_load |-> !(out_valid && out_stall))
    else $error("result overwrote a held beat");

endmodule

FILE: rtl/airw_win_ram.sv
// ----------------------------------------------------------------------------
// airw_win_ram
// Window store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module airw_win_ram (
  input logic clk,
  input logic [airw_pkg::IDX_W-1:0] rd_addr,
  output airw_pkg::win_t rd_data,
  input airw_pkg::win_wr_t wr
);
  import airw_pkg::*;

  win_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/airw_window.sv
// ----------------------------------------------------------------------------
// airw_window
// Serial-number replay window check and update for one entry.
// ----------------------------------------------------------------------------
module airw_window (
  input airw_pkg::win_t cur,
  input logic [31:0] seq,
  output airw_pkg::status_t status,
  output airw_pkg::win_t upd
);
  import airw_pkg::*;

  logic [31:0] fwd;
  logic [31:0] back;
  logic [31:0] bit_m;

  assign fwd = seq - cur.top;
  assign back = cur.top - seq;
  assign bit_m = 32'd1 << back[4:0];

  always_comb begin
    status = ST_OK;
    upd.seq_seen = 1'b1;
    upd.top = seq;
    upd.bits = 32'd1;
    if (!cur.seq_seen) begin
      status = ST_OK;
    end else if (fwd == 32'd0) begin
      status = ST_DUPLICATE;
    end else if (fwd == HALF_RANGE) begin
      status = ST_AMBIGUOUS;
    end else if (fwd < HALF_RANGE) begin
      if (fwd < 32'(WINDOW)) begin
        upd.bits = ((cur.bits << fwd[4:0]) | 32'd1) & WIN_MASK;
      end
    end else if (back >= 32'(WINDOW)) begin
      status = ST_TOO_OLD;
    end else if ((cur.bits & bit_m) != 32'd0) begin
      status = ST_DUPLICATE;
    end else begin
      upd.top = cur.top;
      upd.bits = (cur.bits | bit_m) & WIN_MASK;
    end
  end

endmodule
